>>> hw/rtl/gso_pkg.sv
// types and constants shared by the grid scan order generator
package gso_pkg;

	localparam int DIM_W     = 9;
	localparam int CNT_W     = 17;
	localparam int IDX_W     = 16;
	localparam int PROD_W    = 2 * DIM_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int REG_IDX_W = 3;
	localparam int DATA_W    = CNT_W;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_GRID_COLUMNS  = 3'd0,
		REG_GRID_ROWS     = 3'd1,
		REG_CELL_COUNT    = 3'd2,
		REG_COL_FIRST     = 3'd3,
		REG_SNAKE_MODE    = 3'd4,
		REG_REVERSE_ORDER = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0] cols;
		logic [DIM_W-1:0] rows;
		logic [CNT_W-1:0] cell_count;
		logic             col_first;
		logic             snake_mode;
		logic             reverse_order;
	} cfg_t;

	typedef struct packed {
		logic             done;
		logic             at_end;
		logic [DIM_W-1:0] outer;
		logic [DIM_W-1:0] in_coord;
	} walk_s1_t;

	typedef struct packed {
		logic [IDX_W-1:0] cell_index;
		logic             present;
		logic             last;
		logic             done_res;
	} rsp_t;

endpackage

>>> hw/rtl/gso_if.sv
// request and response channel interfaces of the grid scan order generator
interface gso_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface gso_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] cell_index;
	logic        present;
	logic        last;
	logic        done_res;

	modport source (output valid, output cell_index, output present, output last,
		output done_res, input ready);
	modport sink (input valid, input cell_index, input present, input last,
		input done_res, output ready);
endinterface

>>> hw/rtl/grid_scan_order_generator.sv
// top level of the grid scan order generator
//
// each request on req carries restart: 1 starts the scan at its first
// position, 0 steps to the next position. every request gives exactly one
// response on rsp with cell_index, present, last and done_res; done_res marks
// a step with no position (empty grid, no scan running, or past the end).
// the grid shape and scan mode are set through the cfg write port; the user
// must do so while no request is in flight, which the block does not enforce.
// a request passes through the counter stage, then the index multiply and cell
// count compare feeding the output register.
// throughput is one request per cycle while the receiver takes responses,
// set by the position counters which update in the cycle a request is taken.
// reset clears the pipeline, stops any scan and loads one column, one row,
// one cell, row-major order, no snake, forward walk.
// when the receiver stalls, the output register and the first stage hold,
// and req.ready drops once both are full.
module grid_scan_order_generator #(
	parameter int MAX_DIM = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	gso_req_if.sink                          req,
	gso_rsp_if.source                        rsp,
	input  logic                             cfg_we,
	input  logic [gso_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [gso_pkg::DATA_W-1:0]       cfg_data
);
	import gso_pkg::*;

	logic [DIM_W-1:0] cols_q, rows_q;
	logic [CNT_W-1:0] cell_count_q;
	logic             col_first_q, snake_mode_q, reverse_order_q;
	cfg_t             cfg;
	walk_s1_t         walk_s1;
	rsp_t             rsp_s2;
	logic             valid_s1, valid_s2;
	logic             s2_free, s1_adv, accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q          <= DIM_W'(1);
			rows_q          <= DIM_W'(1);
			cell_count_q    <= CNT_W'(1);
			col_first_q     <= 1'b0;
			snake_mode_q    <= 1'b0;
			reverse_order_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_COLUMNS:  cols_q          <= cfg_data[DIM_W-1:0];
				REG_GRID_ROWS:     rows_q          <= cfg_data[DIM_W-1:0];
				REG_CELL_COUNT:    cell_count_q    <= cfg_data[CNT_W-1:0];
				REG_COL_FIRST:     col_first_q     <= cfg_data[0];
				REG_SNAKE_MODE:    snake_mode_q    <= cfg_data[0];
				REG_REVERSE_ORDER: reverse_order_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// saturate dimensions to the largest supported grid side
	assign cfg.cols = (int'(cols_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : cols_q;
	assign cfg.rows = (int'(rows_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : rows_q;
	assign cfg.cell_count    = cell_count_q;
	assign cfg.col_first     = col_first_q;
	assign cfg.snake_mode    = snake_mode_q;
	assign cfg.reverse_order = reverse_order_q;

	assign s2_free   = !valid_s2 || rsp.ready;
	assign s1_adv    = valid_s1 && s2_free;
	assign req.ready = !valid_s1 || s2_free;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	gso_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.accept  (accept),
		.restart (req.restart),
		.walk_s1 (walk_s1)
	);

	gso_index u_index (
		.clk     (clk),
		.cfg     (cfg),
		.load    (s1_adv),
		.walk_s1 (walk_s1),
		.rsp_s2  (rsp_s2)
	);

	assign rsp.valid      = valid_s2;
	assign rsp.cell_index = rsp_s2.cell_index;
	assign rsp.present    = rsp_s2.present;
	assign rsp.last       = rsp_s2.last;
	assign rsp.done_res   = rsp_s2.done_res;

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.done_res |-> !rsp_s2.present && !rsp_s2.last
		&& rsp_s2.cell_index == '0)
		else $error("done response carries position fields");
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_free |=> valid_s1 && $stable(walk_s1))
		else $error("first stage changed while stalled");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !rsp.ready |=> valid_s2 && $stable(rsp_s2))
		else $error("response overwritten before it was taken");

endmodule

>>> hw/rtl/gso_walk.sv
// scan position counters and first pipeline stage
module gso_walk (
	input  logic              clk,
	input  logic              arst_n,
	input  gso_pkg::cfg_t     cfg,
	input  logic              accept,
	input  logic              restart,
	output gso_pkg::walk_s1_t walk_s1
);
	import gso_pkg::*;

	logic [DIM_W-1:0] outer_q, inner_q;
	logic             active_q;
	logic [DIM_W-1:0] nxt_outer, nxt_inner;
	logic             nxt_active, nxt_done;
	logic [DIM_W-1:0] n_out, n_in, n_out_m1, n_in_m1;
	logic             empty, at_end;
	logic [DIM_W-1:0] in_coord;
	walk_s1_t         walk_s1_q;

	assign n_out    = cfg.col_first ? cfg.cols : cfg.rows;
	assign n_in     = cfg.col_first ? cfg.rows : cfg.cols;
	assign n_out_m1 = n_out - DIM_W'(1);
	assign n_in_m1  = n_in - DIM_W'(1);
	assign empty    = (n_out == '0) || (n_in == '0) || (cfg.cell_count == '0);

	always_comb begin
		nxt_outer  = outer_q;
		nxt_inner  = inner_q;
		nxt_active = active_q;
		nxt_done   = 1'b0;
		if (restart) begin
			if (empty) begin
				nxt_active = 1'b0;
				nxt_outer  = '0;
				nxt_inner  = '0;
				nxt_done   = 1'b1;
			end else begin
				nxt_active = 1'b1;
				nxt_outer  = cfg.reverse_order ? n_out_m1 : '0;
				nxt_inner  = cfg.reverse_order ? n_in_m1 : '0;
			end
		end else if (!active_q || empty || outer_q >= n_out || inner_q >= n_in) begin
			nxt_active = 1'b0;
			nxt_done   = 1'b1;
		end else if (cfg.reverse_order) begin
			if (outer_q == '0 && inner_q == '0) begin
				nxt_active = 1'b0;
				nxt_done   = 1'b1;
			end else if (inner_q == '0) begin
				nxt_outer = outer_q - DIM_W'(1);
				nxt_inner = n_in_m1;
			end else begin
				nxt_inner = inner_q - DIM_W'(1);
			end
		end else begin
			if (outer_q == n_out_m1 && inner_q == n_in_m1) begin
				nxt_active = 1'b0;
				nxt_done   = 1'b1;
			end else if (inner_q == n_in_m1) begin
				nxt_outer = outer_q + DIM_W'(1);
				nxt_inner = '0;
			end else begin
				nxt_inner = inner_q + DIM_W'(1);
			end
		end
	end

	assign at_end = cfg.reverse_order ? (nxt_outer == '0 && nxt_inner == '0)
		: (nxt_outer == n_out_m1 && nxt_inner == n_in_m1);
	assign in_coord = (cfg.snake_mode && nxt_outer[0]) ? (n_in_m1 - nxt_inner) : nxt_inner;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_q  <= '0;
			inner_q  <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			outer_q  <= nxt_outer;
			inner_q  <= nxt_inner;
			active_q <= nxt_active;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			walk_s1_q.done     <= nxt_done;
			walk_s1_q.at_end   <= at_end;
			walk_s1_q.outer    <= nxt_outer;
			walk_s1_q.in_coord <= in_coord;
		end
	end

	assign walk_s1 = walk_s1_q;

	a_restart_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && restart && !empty |=> active_q && !walk_s1_q.done)
		else $error("restart on a non-empty grid did not start a scan");
	a_idle_advance_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !restart && !active_q |=> walk_s1_q.done && !active_q)
		else $error("advance without a running scan did not give done");
	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		accept && nxt_done |=> !active_q)
		else $error("scan still running after a done request");

endmodule

>>> hw/rtl/gso_index.sv
// linear index, presence check and output register
module gso_index (
	input  logic              clk,
	input  gso_pkg::cfg_t     cfg,
	input  logic              load,
	input  gso_pkg::walk_s1_t walk_s1,
	output gso_pkg::rsp_t     rsp_s2
);
	import gso_pkg::*;

	logic [DIM_W-1:0]  mul_a, add_b;
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0]  idx;
	rsp_t              nxt_rsp, rsp_q;

	assign mul_a = cfg.col_first ? walk_s1.in_coord : walk_s1.outer;
	assign add_b = cfg.col_first ? walk_s1.outer : walk_s1.in_coord;
	assign prod  = PROD_W'(mul_a) * PROD_W'(cfg.cols);
	assign idx   = SUM_W'(prod) + SUM_W'(add_b);

	always_comb begin
		if (walk_s1.done) begin
			nxt_rsp = '{cell_index: '0, present: 1'b0, last: 1'b0, done_res: 1'b1};
		end else begin
			nxt_rsp.cell_index = idx[IDX_W-1:0];
			nxt_rsp.present    = idx < SUM_W'(cfg.cell_count);
			nxt_rsp.last       = walk_s1.at_end;
			nxt_rsp.done_res   = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= nxt_rsp;
		end
	end

	assign rsp_s2 = rsp_q;

endmodule

>>> bench/testbench.sv
// self-checking testbench for the grid scan order generator
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import gso_pkg::*;

	localparam int MAX_DIM = 256;
	localparam int WATCHDOG_LIMIT = 500;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;

	gso_req_if req_if ();
	gso_rsp_if rsp_if ();

	grid_scan_order_generator #(.MAX_DIM(MAX_DIM)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow copy of the scan registers and walk state
	logic [DIM_W-1:0] m_cols = 1;
	logic [DIM_W-1:0] m_rows = 1;
	logic [CNT_W-1:0] m_count = 1;
	logic m_colmaj = 0;
	logic m_snake = 0;
	logic m_rev = 0;
	int pos_outer = 0;
	int pos_inner = 0;
	bit scan_on = 0;

	rsp_t positions_due[$];
	int mismatches = 0;
	int requests_sent = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic rsp_t place_position(input int n_out, input int n_in, input int cols);
		int in_coord;
		int idx;
		rsp_t r;
		in_coord = (m_snake && pos_outer[0]) ? n_in - 1 - pos_inner : pos_inner;
		idx = m_colmaj ? in_coord * cols + pos_outer : pos_outer * cols + in_coord;
		r.cell_index = idx[IDX_W-1:0];
		r.present = idx < int'(m_count);
		r.last = m_rev ? (pos_outer == 0 && pos_inner == 0)
			: (pos_outer == n_out - 1 && pos_inner == n_in - 1);
		r.done_res = 1'b0;
		return r;
	endfunction

	function automatic rsp_t next_position(input bit restart);
		int cols;
		int rows;
		int n_out;
		int n_in;
		bit empty;
		rsp_t finished;
		cols = (int'(m_cols) > MAX_DIM) ? MAX_DIM : int'(m_cols);
		rows = (int'(m_rows) > MAX_DIM) ? MAX_DIM : int'(m_rows);
		n_out = m_colmaj ? cols : rows;
		n_in = m_colmaj ? rows : cols;
		empty = n_out == 0 || n_in == 0 || m_count == 0;
		finished = '0;
		finished.done_res = 1'b1;
		if (restart) begin
			scan_on = 0;
			pos_outer = 0;
			pos_inner = 0;
			if (empty)
				return finished;
			scan_on = 1;
			if (m_rev) begin
				pos_outer = n_out - 1;
				pos_inner = n_in - 1;
			end
			return place_position(n_out, n_in, cols);
		end
		if (!scan_on || empty || pos_outer >= n_out || pos_inner >= n_in) begin
			scan_on = 0;
			return finished;
		end
		if (m_rev) begin
			if (pos_outer == 0 && pos_inner == 0) begin
				scan_on = 0;
				return finished;
			end
			if (pos_inner == 0) begin
				pos_outer--;
				pos_inner = n_in - 1;
			end else begin
				pos_inner--;
			end
		end else begin
			if (pos_outer == n_out - 1 && pos_inner == n_in - 1) begin
				scan_on = 0;
				return finished;
			end
			if (pos_inner == n_in - 1) begin
				pos_outer++;
				pos_inner = 0;
			end else begin
				pos_inner++;
			end
		end
		return place_position(n_out, n_in, cols);
	endfunction

	task automatic send_request(input bit restart);
		if ($urandom_range(99) < gap_pct) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.restart <= restart;
		do
			@(posedge clk);
		while (!req_if.ready);
		positions_due.insert(positions_due.size(), next_position(restart));
		requests_sent++;
	endtask

	task automatic settle();
		req_if.valid <= 1'b0;
		while (positions_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t r, input int unsigned v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v[DATA_W-1:0];
		@(posedge clk);
		case (r)
			REG_GRID_COLUMNS: m_cols = v[DIM_W-1:0];
			REG_GRID_ROWS: m_rows = v[DIM_W-1:0];
			REG_CELL_COUNT: m_count = v[CNT_W-1:0];
			REG_COL_FIRST: m_colmaj = v[0];
			REG_SNAKE_MODE: m_snake = v[0];
			REG_REVERSE_ORDER: m_rev = v[0];
			default: ;
		endcase
	endtask

	task automatic set_grid(input int unsigned cols, input int unsigned rows,
		input int unsigned count, input bit colmaj, input bit snake, input bit rev);
		write_reg(REG_GRID_COLUMNS, cols);
		write_reg(REG_GRID_ROWS, rows);
		write_reg(REG_CELL_COUNT, count);
		write_reg(REG_COL_FIRST, colmaj);
		write_reg(REG_SNAKE_MODE, snake);
		write_reg(REG_REVERSE_ORDER, rev);
		cfg_we <= 1'b0;
	endtask

	function automatic int unsigned pick_dim();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 75)
			return $urandom_range(1, 6);
		if (sel < 85)
			return $urandom_range(7, 20);
		if (sel < 92)
			return $urandom_range(1);
		return $urandom_range(240, 511);
	endfunction

	task automatic compare_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0d got %0d", $time, field, want, got);
		end
	endtask

	// response checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (positions_due.size() == 0) begin
				mismatches++;
				$display("%0t: response expected none got index %0d done %0b", $time,
					rsp_if.cell_index, rsp_if.done_res);
			end else begin
				want = positions_due.pop_front();
				compare_field("cell_index", want.cell_index, rsp_if.cell_index);
				compare_field("present", want.present, rsp_if.present);
				compare_field("last", want.last, rsp_if.last);
				compare_field("done_res", want.done_res, rsp_if.done_res);
			end
		end
	end

	// receiver stalls
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_if.ready = 1'b1;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				if (stall_left == 0)
					rsp_if.ready <= 1'b1;
			end else if ($urandom_range(99) < stall_pct) begin
				stall_left = $urandom_range(1, 18);
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	task automatic test_after_reset();
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b0);
	endtask

	task automatic test_empty_grid();
		settle();
		set_grid(0, 3, 5, 0, 0, 0);
		send_request(1'b1);
		send_request(1'b0);
		settle();
		set_grid(3, 0, 5, 1, 0, 0);
		send_request(1'b1);
		settle();
		set_grid(3, 3, 0, 0, 1, 1);
		send_request(1'b1);
	endtask

	// snake walk whose final position lies beyond the cell count
	task automatic test_snake_skip();
		settle();
		set_grid(2, 3, 4, 0, 1, 0);
		send_request(1'b1);
		repeat (6) send_request(1'b0);
	endtask

	task automatic test_extremes();
		settle();
		set_grid(511, 300, 65536, 1, 0, 1);
		send_request(1'b1);
		send_request(1'b0);
		settle();
		set_grid(256, 256, 131071, 0, 1, 0);
		send_request(1'b1);
		send_request(1'b0);
	endtask

	// shrink the grid under a running scan
	task automatic test_mid_scan_change();
		settle();
		set_grid(4, 4, 16, 0, 0, 0);
		send_request(1'b1);
		send_request(1'b0);
		settle();
		write_reg(REG_GRID_COLUMNS, 1);
		cfg_we <= 1'b0;
		send_request(1'b0);
		send_request(1'b0);
	endtask

	task automatic run_random_phase(input bit steady);
		int unsigned cols;
		int unsigned rows;
		int unsigned cells;
		int unsigned count;
		int unsigned sel;
		int steps;
		settle();
		if (steady) begin
			gap_pct = 0;
			stall_pct = 0;
		end else begin
			gap_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
			stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 40);
		end
		cols = pick_dim();
		rows = pick_dim();
		cells = (cols > MAX_DIM ? MAX_DIM : cols) * (rows > MAX_DIM ? MAX_DIM : rows);
		sel = $urandom_range(99);
		if (sel < 50)
			count = cells;
		else if (sel < 80)
			count = $urandom_range(0, cells);
		else if (sel < 85)
			count = 0;
		else
			count = $urandom_range(0, 131071);
		set_grid(cols, rows, count, $urandom_range(1), $urandom_range(1), $urandom_range(1));
		steps = (cells <= 64 ? cells : $urandom_range(10, 60)) + $urandom_range(1, 3);
		// an unrestarted phase carries on the previous scan under the new grid
		send_request($urandom_range(7) != 0);
		repeat (steps - 1) send_request($urandom_range(39) == 0);
	endtask

	task automatic test_random_walks();
		while (requests_sent < 1200)
			run_random_phase(1'b0);
	endtask

	task automatic test_steady_tail();
		while (requests_sent < 1300)
			run_random_phase(1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.restart = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_GRID_COLUMNS;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct = 20;
		stall_pct = 20;
		test_after_reset();
		test_empty_grid();
		test_snake_skip();
		test_extremes();
		test_mid_scan_change();
		test_random_walks();
		test_steady_tail();
		settle();
		repeat (5) @(posedge clk);
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule
